FILE: src/pcen_pkg.sv
// Shared constants for the per-channel energy normalizer.
package pcen_pkg;

	// Pipeline depths of the power and divide units, input register included
	localparam int POW_LAT = 35;
	localparam int DIV_LAT = 33;

	// Fixed-point special values
	localparam logic [16:0] S_ONE  = 17'd65536;
	localparam logic [17:0] P_TWO  = 18'd131072;
	localparam logic [17:0] P_HALF = 18'd32768;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EPS    = 3'd4;

endpackage

FILE: src/pcen_ifs.sv
// Stream and configuration channel interfaces.
interface pcen_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] energy;
	logic        first_frame;
	logic        frame_end;
	modport source(output valid, energy, first_frame, frame_end, input ready);
	modport sink(input valid, energy, first_frame, frame_end, output ready);
endinterface

interface pcen_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] normalized;
	logic               frame_done;
	modport source(output valid, normalized, frame_done, input ready);
	modport sink(input valid, normalized, frame_done, output ready);
endinterface

interface pcen_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/pcen_channel_energy_normalizer.sv
// Per-channel energy normalization: smoothing, gain division and root compression.
// Throughput: one item per cycle unless the output stalls; the smoothing
// read-modify-write, the three power pipelines and the bit-per-stage divider
// are all fully pipelined. A stall on the output freezes every stage. Reset
// clears valids, channel index, register defaults and the smoothed-energy
// valid bits at once.
module pcen_channel_energy_normalizer #(
	parameter int NUM_CHANNELS = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	pcen_in_if.sink      din,
	pcen_out_if.source   dout,
	pcen_cfg_if.sink     cfg
);
	import pcen_pkg::*;

	localparam int CH_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
	localparam int PIPE = POW_LAT + DIV_LAT + POW_LAT;
	localparam int DIV_AT = POW_LAT;

	// Configuration registers
	logic [16:0] smooth_q;
	logic [17:0] alpha_q;
	logic [17:0] gamma_q;
	logic [31:0] delta_q;
	logic [16:0] eps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= 17'd1638;
			alpha_q  <= 18'd64225;
			gamma_q  <= 18'd32768;
			delta_q  <= 32'd131072;
			eps_q    <= 17'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SMOOTH: smooth_q <= cfg.data[16:0];
				REG_ALPHA:  alpha_q  <= cfg.data[17:0];
				REG_GAMMA:  gamma_q  <= cfg.data[17:0];
				REG_DELTA:  delta_q  <= cfg.data;
				REG_EPS:    eps_q    <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	// Clamped register values
	logic [16:0] s_eff;
	logic [17:0] a_eff, g_eff;
	logic [31:0] eps_eff;
	assign s_eff   = (smooth_q > S_ONE) ? S_ONE : smooth_q;
	assign a_eff   = (alpha_q > P_TWO) ? P_TWO : alpha_q;
	assign g_eff   = (gamma_q > P_TWO) ? P_TWO : gamma_q;
	assign eps_eff = (eps_q == '0) ? 32'd1 : {15'b0, eps_q};

	// Global advance: all stages move unless the output holds a waiting item
	logic out_v_q;
	logic en, acc_in;
	assign en        = !out_v_q || dout.ready;
	assign din.ready = en;
	assign acc_in    = din.valid && en;

	// Channel counter
	logic [CH_W-1:0] ch_idx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_idx_q <= '0;
		end else if (acc_in) begin
			if (din.frame_end || ch_idx_q == CH_W'(NUM_CHANNELS - 1)) ch_idx_q <= '0;
			else ch_idx_q <= ch_idx_q + 1'b1;
		end
	end

	// Stage 1: item registered, smoothed energy read
	logic            v_s1;
	logic [CH_W-1:0] ch_s1;
	logic [31:0]     e_s1;
	logic            ff_s1, fe_s1;
	logic [31:0]     ram_rd;
	logic [31:0]     m_new;
	logic            wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= din.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1 <= ch_idx_q;
			e_s1  <= din.energy;
			ff_s1 <= din.first_frame;
			fe_s1 <= din.frame_end;
		end
	end

	assign wr_en = v_s1 && en;

	pcen_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_sm_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ch_s1),
		.wdata (m_new),
		.re    (acc_in),
		.raddr (ch_idx_q),
		.rdata (ram_rd)
	);

	// Entry valid bits and forwarding of the latest write
	logic [NUM_CHANNELS-1:0] sm_valid_q;
	logic                    fwd_v_q;
	logic [CH_W-1:0]         fwd_ch_q;
	logic [31:0]             fwd_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_valid_q <= '0;
			fwd_v_q    <= 1'b0;
		end else if (wr_en) begin
			sm_valid_q[ch_s1] <= 1'b1;
			fwd_v_q           <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_ch_q <= ch_s1;
			fwd_m_q  <= m_new;
		end
	end

	// Smoothing: M = prev + round(s * (E - prev) / 2^16), or M = E on a first frame
	logic [31:0]        prev;
	logic signed [32:0] dlt;
	logic signed [50:0] sprod, srnd;
	logic signed [34:0] tq;
	logic [33:0]        msum;

	always_comb begin
		if (fwd_v_q && fwd_ch_q == ch_s1) prev = fwd_m_q;
		else if (sm_valid_q[ch_s1]) prev = ram_rd;
		else prev = '0;
	end

	assign dlt   = $signed({1'b0, e_s1}) - $signed({1'b0, prev});
	assign sprod = dlt * $signed({1'b0, s_eff});
	assign srnd  = sprod + 51'sd32768;
	assign tq    = $signed(srnd[50:16]);
	assign msum  = {2'b0, prev} + $unsigned(tq[33:0]);
	assign m_new = ff_s1 ? e_s1 : msum[31:0];

	// Stage 2: smoothed energy, with epsilon in place of zero
	logic        v_s2, fe_s2;
	logic [31:0] e_s2, m_s2, mm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2  <= e_s1;
			fe_s2 <= fe_s1;
			m_s2  <= m_new;
		end
	end

	assign mm = (m_s2 == '0) ? eps_eff : m_s2;

	// Valid and sideband delay lines beside the arithmetic units
	logic [PIPE-1:0] vd_q, fd_q;
	logic [31:0]     ed_q [POW_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_q <= '0;
		else if (en) vd_q <= {vd_q[PIPE-2:0], v_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fd_q     <= {fd_q[PIPE-2:0], fe_s2};
			ed_q[0]  <= e_s2;
			for (int i = 1; i < POW_LAT; i++) ed_q[i] <= ed_q[i-1];
		end
	end

	// M^alpha, then E / M^alpha
	logic [63:0] pa;
	logic [31:0] ratio;

	pcen_pow u_pow_a (.clk(clk), .en(en), .x(mm), .p(a_eff), .y(pa));

	pcen_div u_div (.clk(clk), .en(en), .num(ed_q[DIV_AT-1]), .den(pa), .quo(ratio));

	// Offset add, saturating, then both compressions
	logic [32:0] qsum;
	logic [31:0] qv;
	logic [63:0] pg, pb;

	assign qsum = {1'b0, ratio} + {1'b0, delta_q};
	assign qv   = qsum[32] ? 32'hFFFF_FFFF : qsum[31:0];

	pcen_pow u_pow_g (.clk(clk), .en(en), .x(qv), .p(g_eff), .y(pg));
	pcen_pow u_pow_d (.clk(clk), .en(en), .x(delta_q), .p(g_eff), .y(pb));

	// Difference saturated to signed Q16.16
	logic signed [48:0] diff;
	logic signed [31:0] norm;

	assign diff = $signed({1'b0, pg[63:16]}) - $signed({1'b0, pb[63:16]});

	always_comb begin
		if (diff > 49'sd2147483647) norm = 32'sh7FFF_FFFF;
		else if (diff < -49'sd2147483648) norm = 32'sh8000_0000;
		else norm = diff[31:0];
	end

	// Output register
	logic signed [31:0] norm_q;
	logic               fdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= vd_q[PIPE-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q  <= norm;
			fdone_q <= fd_q[PIPE-1];
		end
	end

	assign dout.valid      = out_v_q;
	assign dout.normalized = norm_q;
	assign dout.frame_done = fdone_q;
endmodule

FILE: src/pcen_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcen_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

FILE: src/pcen_pow.sv
// Pipelined x^p: Q16.16 base, Q2.16 exponent, saturated Q32.32 result.
module pcen_pow (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x,
	input  logic [17:0] p,
	output logic [63:0] y
);
	import pcen_pkg::*;

	localparam int NST = POW_LAT - 1;

	typedef struct packed {
		logic        zero;
		logic        pz;
		logic        sq_m;
		logic        rt_m;
		logic [17:0] p;
		logic [4:0]  n;
		logic [31:0] m;
		logic [15:0] lf;
		logic [63:0] sqv;
		logic [47:0] iv;
		logic [47:0] ir;
		logic [23:0] yb;
		logic [31:0] acc;
		logic [63:0] res;
	} pow_st_t;

	// Elaboration-time integer square root
	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] r, b, w;
		r = '0;
		w = v;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (w >= r + b) begin
				w = w - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q1.31 by repeated floored roots of 2.0
	function automatic logic [31:0] root_c(input int k);
		logic [63:0] r;
		r = 64'h1_0000_0000;
		for (int i = 0; i < k; i++) r = isqrt_c(r << 31);
		return r[31:0];
	endfunction

	// Trial bit of the square-root step done in stage j
	function automatic logic [47:0] sbit_c(input int j);
		logic [47:0] b;
		b = '0;
		if (j >= 1 && j <= 24) b = 48'd1 << (46 - 2 * (j - 1));
		return b;
	endfunction

	pow_st_t st [0:NST];
	pow_st_t s0;
	logic [4:0] n0;

	// Input stage: leading one, normalized mantissa, exact square
	always_comb begin
		n0 = '0;
		for (int i = 0; i < 32; i++) if (x[i]) n0 = 5'(i);
	end

	always_comb begin
		s0      = '0;
		s0.zero = (x == '0);
		s0.pz   = (p == '0);
		s0.sq_m = (p == P_TWO);
		s0.rt_m = (p == P_HALF);
		s0.p    = p;
		s0.n    = n0;
		s0.m    = x << (5'd31 - n0);
		s0.sqv  = x * x;
		s0.iv   = {x, 16'b0};
	end

	always_ff @(posedge clk) begin
		if (en) st[0] <= s0;
	end

	for (genvar j = 1; j <= NST; j++) begin : g_st
		localparam logic [31:0] RK = root_c((j >= 18 && j <= 33) ? j - 17 : 0);
		localparam logic [47:0] SB = sbit_c(j);
		localparam int FB = (j >= 18 && j <= 33) ? 33 - j : 0;

		pow_st_t            nx;
		logic [63:0]        sqm;
		logic [63:0]        pacc;
		logic [48:0]        tr;
		logic [38:0]        prod_l;
		logic [39:0]        yv;
		logic signed [8:0]  sh;
		logic [8:0]         nsh;
		logic [63:0]        ev;

		assign sqm    = st[j-1].m * st[j-1].m;
		assign pacc   = st[j-1].acc * RK;
		assign tr     = {1'b0, st[j-1].ir} + {1'b0, SB};
		assign prod_l = st[j-1].p * {st[j-1].n, st[j-1].lf};
		assign yv     = {1'b0, prod_l} + (40'd1 << 37) - ({22'b0, st[j-1].p} << 20);
		assign sh     = $signed({1'b0, st[j-1].yb[23:16]}) - 9'sd31;
		assign nsh    = 9'(-sh);

		// Final shift of the exp2 mantissa, saturating on overflow
		always_comb begin
			if (!sh[8] && sh >= 9'sd33) ev = '1;
			else if (!sh[8]) ev = {32'b0, st[j-1].acc} << sh[5:0];
			else ev = {32'b0, st[j-1].acc} >> nsh[5:0];
		end

		always_comb begin
			nx = st[j-1];
			// log2 mantissa squaring, one fraction bit a stage
			if (j <= 16) begin
				if (sqm[63]) begin
					nx.m  = sqm[63:32];
					nx.lf = {st[j-1].lf[14:0], 1'b1};
				end else begin
					nx.m  = sqm[62:31];
					nx.lf = {st[j-1].lf[14:0], 1'b0};
				end
			end
			// square root, one result bit a stage
			if (j <= 24) begin
				if ({1'b0, st[j-1].iv} >= tr) begin
					nx.iv = st[j-1].iv - tr[47:0];
					nx.ir = (st[j-1].ir >> 1) + SB;
				end else begin
					nx.ir = st[j-1].ir >> 1;
				end
			end
			// scaled exponent y = p * log2(x)
			if (j == 17) begin
				nx.yb  = yv[39:16];
				nx.acc = 32'h8000_0000;
			end
			// exp2 of the fraction, one root a stage
			if (j >= 18 && j <= 33) begin
				if (st[j-1].yb[FB]) nx.acc = pacc[62:31];
			end
			// result select
			if (j == 34) begin
				if (st[j-1].zero) nx.res = st[j-1].pz ? 64'h1_0000_0000 : 64'h0;
				else if (st[j-1].sq_m) nx.res = st[j-1].sqv;
				else if (st[j-1].rt_m) nx.res = {st[j-1].ir, 16'b0};
				else nx.res = ev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) st[j] <= nx;
		end
	end

	assign y = st[NST].res;
endmodule

FILE: src/pcen_div.sv
// Pipelined restoring divide: 32-bit quotient of num/den, saturating.
module pcen_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [63:0] den,
	output logic [31:0] quo
);
	import pcen_pkg::*;

	localparam int NST = DIV_LAT - 1;

	typedef struct packed {
		logic        ovf;
		logic [63:0] rem;
		logic [63:0] d;
		logic [31:0] q;
	} div_st_t;

	div_st_t st [0:NST];

	// Input stage; a quotient that does not fit saturates
	always_ff @(posedge clk) begin
		if (en) begin
			st[0].ovf <= ({32'b0, num} >= den);
			st[0].rem <= {32'b0, num};
			st[0].d   <= den;
			st[0].q   <= '0;
		end
	end

	for (genvar j = 1; j <= NST; j++) begin : g_st
		div_st_t     nx;
		logic [63:0] r2;

		assign r2 = {st[j-1].rem[62:0], 1'b0};

		// One quotient bit a stage
		always_comb begin
			nx = st[j-1];
			if (st[j-1].rem[63] || r2 >= st[j-1].d) begin
				nx.rem = r2 - st[j-1].d;
				nx.q   = {st[j-1].q[30:0], 1'b1};
			end else begin
				nx.rem = r2;
				nx.q   = {st[j-1].q[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) st[j] <= nx;
		end
	end

	assign quo = st[NST].ovf ? 32'hFFFF_FFFF : st[NST].q;
endmodule
